### rtl/core/pgb_pkg.sv
`timescale 1ns / 1ps
package pgb_pkg;

    localparam int GLYPH_HEIGHT = 12;
    localparam int ADDR_BITS    = 20;
    localparam int QUEUE_DEPTH  = 2;

    localparam int LEFT_W  = $clog2(255 * GLYPH_HEIGHT + 1);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0]  CFG_DEST_STRIDE = 2'd0;
    localparam logic [1:0]  CFG_WIDTH_LIMIT = 2'd1;
    localparam logic [1:0]  CFG_GLYPH_COUNT = 2'd2;

    localparam logic        OP_START  = 1'b0;
    localparam logic        OP_BITMAP = 1'b1;
    localparam logic        KIND_ADVANCE = 1'b0;
    localparam logic        KIND_PIXEL   = 1'b1;

    localparam logic [7:0]  ADV_MISSING    = 8'd4;
    localparam logic [15:0] COLOR_OPAQUE   = 16'h8000;
    localparam logic [10:0] STRIDE_RESET   = 11'd256;
    localparam logic [10:0] LIMIT_RESET    = 11'd256;
    localparam logic [15:0] COUNT_RESET    = 16'd0;

    typedef logic [ADDR_BITS-1:0] t_addr;

    // one classified item handed from the front part to the back part
    typedef struct packed {
        logic              is_start;
        logic              draw;
        logic [7:0]        advance;
        t_addr             row_base;
        logic [7:0]        width;
        logic [15:0]       color;
        logic [LEFT_W-1:0] pixels;
        logic [7:0]        bits;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [7:0]  advance;
        logic [19:0] address;
        logic [15:0] pixel_color;
        logic        last;
    } t_result;

endpackage

### rtl/core/pgb_item_if.sv
`timescale 1ns / 1ps
interface pgb_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [15:0] glyph_code;
    logic [7:0]  glyph_width;
    logic [15:0] color;
    logic [7:0]  bitmap_byte;

    modport source (output valid, op, pos_x, pos_y, glyph_code, glyph_width, color,
                    bitmap_byte, input ready);
    modport sink (input valid, op, pos_x, pos_y, glyph_code, glyph_width, color,
                  bitmap_byte, output ready);
endinterface

### rtl/core/pgb_result_if.sv
`timescale 1ns / 1ps
interface pgb_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  advance;
    logic [19:0] address;
    logic [15:0] pixel_color;
    logic        last;

    modport source (output valid, kind, advance, address, pixel_color, last,
                    input ready);
    modport sink (input valid, kind, advance, address, pixel_color, last,
                  output ready);
endinterface

### rtl/core/pgb_front.sv
`timescale 1ns / 1ps
module pgb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    pgb_item_if.sink            i_item,
    input  logic                i_full,
    output logic                o_push,
    output pgb_pkg::t_cmd       o_cmd,
    output logic [10:0]         o_stride
);

    logic [10:0] r_stride;
    logic [10:0] r_limit;
    logic [15:0] r_count;

    logic        code_ok;
    logic        edge_ok;
    logic [10:0] right_edge;
    logic [20:0] row_offset;
    logic [21:0] start_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= pgb_pkg::STRIDE_RESET;
            r_limit  <= pgb_pkg::LIMIT_RESET;
            r_count  <= pgb_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pgb_pkg::CFG_DEST_STRIDE: r_stride <= i_cfg_data[10:0];
                pgb_pkg::CFG_WIDTH_LIMIT: r_limit  <= i_cfg_data[10:0];
                pgb_pkg::CFG_GLYPH_COUNT: r_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        code_ok    = (i_item.glyph_code < r_count) && (i_item.glyph_width != 8'd0);
        right_edge = 11'(i_item.pos_x) + 11'(i_item.glyph_width);
        edge_ok    = right_edge <= r_limit;
        row_offset = 21'(i_item.pos_y) * 21'(r_stride);
        start_sum  = 22'(i_item.pos_x) + 22'(row_offset);

        o_cmd.is_start = i_item.op == pgb_pkg::OP_START;
        o_cmd.draw     = code_ok && edge_ok;
        o_cmd.advance  = code_ok ? i_item.glyph_width : pgb_pkg::ADV_MISSING;
        o_cmd.row_base = pgb_pkg::ADDR_BITS'(start_sum);
        o_cmd.width    = i_item.glyph_width;
        o_cmd.color    = i_item.color | pgb_pkg::COLOR_OPAQUE;
        o_cmd.pixels   = pgb_pkg::LEFT_W'(i_item.glyph_width * pgb_pkg::GLYPH_HEIGHT);
        o_cmd.bits     = i_item.bitmap_byte;
    end

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;
    assign o_stride     = r_stride;

endmodule

### rtl/core/pgb_queue.sv
`timescale 1ns / 1ps
module pgb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pgb_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pgb_pkg::t_cmd o_cmd
);

    pgb_pkg::t_cmd                 r_mem [pgb_pkg::QUEUE_DEPTH];
    logic [pgb_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [pgb_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [pgb_pkg::QCNT_W-1:0]    r_count;

    function automatic logic [pgb_pkg::QPTR_W-1:0] bump(
        input logic [pgb_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == pgb_pkg::QPTR_W'(pgb_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = r_count == pgb_pkg::QCNT_W'(pgb_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pgb_pkg::QCNT_W'(pgb_pkg::QUEUE_DEPTH))
        else $error("queue count overrun");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("push lost");

endmodule

### rtl/core/pgb_back.sv
`timescale 1ns / 1ps
module pgb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [10:0]   i_stride,
    input  logic          i_valid,
    input  pgb_pkg::t_cmd i_cmd,
    output logic          o_pop,
    pgb_result_if.source  o_result
);

    logic                       r_drawing;
    logic [7:0]                 r_cur_width;
    logic [7:0]                 r_column;
    pgb_pkg::t_addr             r_row_base;
    logic [15:0]                r_draw_color;
    logic [pgb_pkg::LEFT_W-1:0] r_left;
    logic                       r_busy;
    logic [7:0]                 r_bits;
    logic [2:0]                 r_step;
    logic                       r_out_valid;
    pgb_pkg::t_result           r_out;

    logic                       n_drawing;
    logic [7:0]                 n_cur_width;
    logic [7:0]                 n_column;
    pgb_pkg::t_addr             n_row_base;
    logic [15:0]                n_draw_color;
    logic [pgb_pkg::LEFT_W-1:0] n_left;
    logic                       n_busy;
    logic [7:0]                 n_bits;
    logic [2:0]                 n_step;
    logic                       n_out_valid;
    pgb_pkg::t_result           n_out;

    logic                       can_emit;
    logic [7:0]                 live_mask;
    pgb_pkg::t_addr             pix_addr;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            live_mask[i] = pgb_pkg::LEFT_W'(i) < r_left;
        end
        pix_addr = r_row_base + pgb_pkg::ADDR_BITS'(r_column);
        can_emit = !r_out_valid || o_result.ready;

        n_drawing    = r_drawing;
        n_cur_width  = r_cur_width;
        n_column     = r_column;
        n_row_base   = r_row_base;
        n_draw_color = r_draw_color;
        n_left       = r_left;
        n_busy       = r_busy;
        n_bits       = r_bits;
        n_step       = r_step;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out        = r_out;
        o_pop        = 1'b0;

        if (r_busy) begin
            // a clear bit never waits on the output
            if (!r_bits[0] || can_emit) begin
                if (r_bits[0]) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = pgb_pkg::KIND_PIXEL;
                    n_out.advance     = 8'd0;
                    n_out.address     = 20'(pix_addr);
                    n_out.pixel_color = r_draw_color;
                    n_out.last        = r_bits[7:1] == 7'd0;
                end
                n_bits = r_bits >> 1;
                n_step = r_step + 3'd1;
                n_left = r_left - 1'b1;
                if (r_column + 8'd1 == r_cur_width) begin
                    n_column   = 8'd0;
                    n_row_base = r_row_base + pgb_pkg::ADDR_BITS'(i_stride);
                end else begin
                    n_column = r_column + 8'd1;
                end
                if (r_left == pgb_pkg::LEFT_W'(1)) begin
                    n_drawing = 1'b0;
                    n_busy    = 1'b0;
                end
                if (r_step == 3'd7) begin
                    n_busy = 1'b0;
                end
            end
        end else if (i_valid) begin
            if (i_cmd.is_start) begin
                if (can_emit) begin
                    o_pop             = 1'b1;
                    n_out_valid       = 1'b1;
                    n_out.kind        = pgb_pkg::KIND_ADVANCE;
                    n_out.advance     = i_cmd.advance;
                    n_out.address     = 20'd0;
                    n_out.pixel_color = 16'd0;
                    n_out.last        = 1'b1;
                    n_drawing         = i_cmd.draw;
                    n_cur_width       = i_cmd.width;
                    n_column          = 8'd0;
                    n_row_base        = i_cmd.row_base;
                    n_draw_color      = i_cmd.color;
                    n_left            = i_cmd.pixels;
                end
            end else begin
                // drop bitmap bytes that arrive with no glyph open
                o_pop = 1'b1;
                if (r_drawing) begin
                    n_busy = 1'b1;
                    n_bits = i_cmd.bits & live_mask;
                    n_step = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawing    <= 1'b0;
            r_cur_width  <= 8'd0;
            r_column     <= 8'd0;
            r_row_base   <= '0;
            r_draw_color <= 16'd0;
            r_left       <= '0;
            r_busy       <= 1'b0;
            r_step       <= 3'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_drawing    <= n_drawing;
            r_cur_width  <= n_cur_width;
            r_column     <= n_column;
            r_row_base   <= n_row_base;
            r_draw_color <= n_draw_color;
            r_left       <= n_left;
            r_busy       <= n_busy;
            r_step       <= n_step;
            r_out_valid  <= n_out_valid;
        end
        r_bits <= n_bits;
        r_out  <= n_out;
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.kind        = r_out.kind;
    assign o_result.advance     = r_out.advance;
    assign o_result.address     = r_out.address;
    assign o_result.pixel_color = r_out.pixel_color;
    assign o_result.last        = r_out.last;

    a_busy_drawing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_drawing && r_left != '0))
        else $error("bit stepper running without an open glyph");

    a_pixel_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == pgb_pkg::KIND_PIXEL) |-> r_out.pixel_color[15])
        else $error("pixel colour missing opaque bit");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_pop)
        else $error("queue popped while a byte is in progress");

endmodule

### rtl/core/proportional_glyph_blitter.sv
`timescale 1ns / 1ps
// A start item passes the queue and the back part registers its advance answer; the set bits of
// a bitmap byte leave as pixel writes, lowest bit first. The back part takes a start item only
// when the output can take its answer; it loads a bitmap byte, then steps through up to eight
// bits, fewer when the glyph ends early, taking no item meanwhile; a held output stalls set bits.
// A two-entry queue decouples front and back. Synchronous reset (i_rst_n low) closes any glyph,
// empties the queue and restores stride 256, width limit 256 and glyph count 0.
module proportional_glyph_blitter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    pgb_item_if.sink      i_item,
    pgb_result_if.source  o_result
);

    logic          push;
    logic          pop;
    logic          full;
    logic          q_valid;
    logic [10:0]   stride;
    pgb_pkg::t_cmd push_cmd;
    pgb_pkg::t_cmd head_cmd;

    pgb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_stride    (stride)
    );

    pgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    pgb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stride (stride),
        .i_valid  (q_valid),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 40;
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic        op;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [15:0] glyph_code;
        logic [7:0]  glyph_width;
        logic [15:0] color;
        logic [7:0]  bitmap_byte;
    } t_glyph_item;

    class blit_scoreboard;
        logic [10:0]        stride;
        logic [10:0]        limit_col;
        logic [15:0]        glyph_count;
        bit                 drawing;
        logic [7:0]         cur_width;
        logic [7:0]         column;
        logic [5:0]         row;
        pgb_pkg::t_addr     row_base;
        logic [15:0]        draw_color;
        pgb_pkg::t_result   expected_writes[$];
        int                 errors;

        function new();
            stride      = pgb_pkg::STRIDE_RESET;
            limit_col   = pgb_pkg::LIMIT_RESET;
            glyph_count = pgb_pkg::COUNT_RESET;
            drawing     = 0;
            cur_width   = 0;
            column      = 0;
            row         = 0;
            row_base    = '0;
            draw_color  = 0;
            errors      = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void set_reg(logic [1:0] index, logic [15:0] data);
            case (index)
                pgb_pkg::CFG_DEST_STRIDE: stride      = data[10:0];
                pgb_pkg::CFG_WIDTH_LIMIT: limit_col   = data[10:0];
                pgb_pkg::CFG_GLYPH_COUNT: glyph_count = data;
                default: ;
            endcase
        endfunction

        // Work out the results one accepted item causes and queue them.
        function void accept_item(t_glyph_item it);
            pgb_pkg::t_result r;
            pgb_pkg::t_result pix[$];
            logic [31:0]      base;
            logic [7:0]       bits;
            if (it.op == pgb_pkg::OP_START) begin
                drawing = 0;
                r = '0;
                r.kind = pgb_pkg::KIND_ADVANCE;
                r.last = 1'b1;
                if (it.glyph_code >= glyph_count || it.glyph_width == 0) begin
                    r.advance = pgb_pkg::ADV_MISSING;
                end else if (int'(it.pos_x) + int'(it.glyph_width) > int'(limit_col)) begin
                    r.advance = it.glyph_width;
                end else begin
                    r.advance  = it.glyph_width;
                    drawing    = 1;
                    cur_width  = it.glyph_width;
                    column     = 0;
                    row        = 0;
                    base       = 32'(it.pos_x) + 32'(it.pos_y) * 32'(stride);
                    row_base   = base[pgb_pkg::ADDR_BITS-1:0];
                    draw_color = it.color | pgb_pkg::COLOR_OPAQUE;
                end
                expected_writes.push_back(r);
                return;
            end
            bits = it.bitmap_byte;
            for (int b = 0; b < 8 && drawing; b++) begin
                if (bits[0]) begin
                    r = '0;
                    r.kind        = pgb_pkg::KIND_PIXEL;
                    r.address     = 20'(pgb_pkg::t_addr'(row_base + pgb_pkg::t_addr'(column)));
                    r.pixel_color = draw_color;
                    pix.push_back(r);
                end
                bits   = bits >> 1;
                column = column + 8'd1;
                if (column >= cur_width) begin
                    column   = 0;
                    row      = row + 6'd1;
                    row_base = pgb_pkg::t_addr'(row_base + pgb_pkg::t_addr'(stride));
                    if (row >= pgb_pkg::GLYPH_HEIGHT)
                        drawing = 0;
                end
            end
            if (pix.size() > 0)
                pix[pix.size()-1].last = 1'b1;
            foreach (pix[i])
                expected_writes.push_back(pix[i]);
        endfunction

        function void check_result(pgb_pkg::t_result got);
            pgb_pkg::t_result exp;
            if (expected_writes.size() == 0) begin
                report($sformatf("unexpected result: kind %0d adv %0d addr %h colour %h last %0d",
                                 got.kind, got.advance, got.address, got.pixel_color, got.last));
                return;
            end
            exp = expected_writes.pop_front();
            if (got.kind != exp.kind || got.advance != exp.advance ||
                got.address != exp.address || got.pixel_color != exp.pixel_color ||
                got.last != exp.last)
                report($sformatf({"mismatch (exp/got): kind %0d/%0d adv %0d/%0d ",
                                  "addr %h/%h colour %h/%h last %0d/%0d"},
                                 exp.kind, got.kind, exp.advance, got.advance,
                                 exp.address, got.address, exp.pixel_color,
                                 got.pixel_color, exp.last, got.last));
        endfunction

        function void close_out();
            if (expected_writes.size() != 0)
                report($sformatf("%0d expected results never arrived",
                                 expected_writes.size()));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    pgb_item_if   item_ch ();
    pgb_result_if result_ch ();

    proportional_glyph_blitter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    blit_scoreboard sb = new();
    bit idle_en;
    bit hold_req;
    bit hold_done;
    int n_counted;
    int quiet_cycles;

    always #2 i_clk = ~i_clk;

    // result side: random stalls plus one long hold-off on request
    initial begin
        result_ch.ready <= 1'b0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n) begin
                if (hold_req && !hold_done) begin
                    result_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    hold_done = 1;
                end
                if (idle_en && $urandom_range(0, 4) == 0) begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(negedge i_clk);
                end
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        pgb_pkg::t_result got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.kind        = result_ch.kind;
            got.advance     = result_ch.advance;
            got.address     = result_ch.address;
            got.pixel_color = result_ch.pixel_color;
            got.last        = result_ch.last;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no traffic for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(t_glyph_item it);
        if (!(it.op == pgb_pkg::OP_BITMAP && !sb.drawing))
            n_counted++;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_ch.valid       <= 1'b1;
        item_ch.op          <= it.op;
        item_ch.pos_x       <= it.pos_x;
        item_ch.pos_y       <= it.pos_y;
        item_ch.glyph_code  <= it.glyph_code;
        item_ch.glyph_width <= it.glyph_width;
        item_ch.color       <= it.color;
        item_ch.bitmap_byte <= it.bitmap_byte;
        do @(posedge i_clk); while (!item_ch.ready);
        sb.accept_item(it);
    endtask

    task automatic send_start(int px, int py, int code, int w, int colr);
        t_glyph_item it;
        it             = '0;
        it.op          = pgb_pkg::OP_START;
        it.pos_x       = px[9:0];
        it.pos_y       = py[9:0];
        it.glyph_code  = code[15:0];
        it.glyph_width = w[7:0];
        it.color       = colr[15:0];
        send_item(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        t_glyph_item it;
        it             = '0;
        it.op          = pgb_pkg::OP_BITMAP;
        it.bitmap_byte = b;
        it.pos_x       = 10'($urandom);
        it.glyph_code  = 16'($urandom);
        send_item(it);
    endtask

    function automatic logic [7:0] pick_bits();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // hold input, let every expected result arrive, then let the block go quiet
    task automatic drain();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (sb.expected_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        sb.set_reg(index, data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic configure(int stride, int lim, int count);
        drain();
        write_reg(pgb_pkg::CFG_DEST_STRIDE, 16'(stride));
        write_reg(pgb_pkg::CFG_WIDTH_LIMIT, 16'(lim));
        write_reg(pgb_pkg::CFG_GLYPH_COUNT, 16'(count));
    endtask

    task automatic noise_item();
        if ($urandom_range(0, 1) == 0)
            send_start($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 65535), $urandom_range(0, 255),
                       $urandom_range(0, 65535));
        else
            send_byte(8'($urandom));
    endtask

    // well-formed glyph with random content; sometimes cut short or overrun
    task automatic random_glyph();
        int w;
        int hi;
        int nbytes;
        if (sb.limit_col == 0 || sb.glyph_count == 0) begin
            noise_item();
            return;
        end
        case ($urandom_range(0, 29))
            0:       w = $urandom_range(100, 255);
            1, 2, 3: w = $urandom_range(9, 24);
            default: w = $urandom_range(1, 8);
        endcase
        if (w > int'(sb.limit_col))
            w = int'(sb.limit_col);
        hi = int'(sb.limit_col) - w;
        if (hi > 1023)
            hi = 1023;
        send_start($urandom_range(0, hi), $urandom_range(0, 1023),
                   $urandom_range(0, int'(sb.glyph_count) - 1), w,
                   $urandom_range(0, 65535));
        nbytes = (w * pgb_pkg::GLYPH_HEIGHT + 7) / 8;
        if (w >= 100 || $urandom_range(0, 7) == 0)
            nbytes = $urandom_range(0, nbytes < 6 ? nbytes : 6);
        else if ($urandom_range(0, 7) == 0)
            nbytes += $urandom_range(1, 3);
        repeat (nbytes) send_byte(pick_bits());
    endtask

    task automatic random_phase(int goal, bit with_hold);
        int stop_at;
        stop_at = n_counted + goal;
        while (n_counted < stop_at) begin
            if (with_hold && n_counted > stop_at - goal + 10)
                hold_req = 1;
            if ($urandom_range(0, 4) == 0)
                noise_item();
            else
                random_glyph();
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= pgb_pkg::CFG_DEST_STRIDE;
        i_cfg_data          <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.op          <= pgb_pkg::OP_START;
        item_ch.pos_x       <= '0;
        item_ch.pos_y       <= '0;
        item_ch.glyph_code  <= '0;
        item_ch.glyph_width <= '0;
        item_ch.color       <= '0;
        item_ch.bitmap_byte <= '0;
        idle_en   = 1;
        hold_req  = 0;
        n_counted = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty font, so every start is refused
        send_start(0, 0, 0, 5, 16'h1234);
        send_byte(8'hFF);

        configure(256, 256, 100);
        send_start(0, 0, 0, 3, 16'h0000);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'hFF);
        send_byte(8'hFF);       // glyph ends mid-byte
        send_byte(8'hFF);       // idle again: dropped
        send_start(10, 10, 1, 0, 16'h00FF);
        send_start(10, 10, 100, 5, 16'h00FF);
        send_start(250, 3, 99, 7, 16'h0F0F);
        send_start(249, 1023, 99, 7, 16'hFFFF);
        send_byte(8'h81);
        send_start(1023, 1023, 65535, 255, 16'hFFFF);   // abandons the glyph
        send_byte(8'h3C);

        configure(2047, 2047, 65535);
        send_start(1023, 1023, 65534, 255, 16'h7FFF);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_start(0, 0, 65535, 1, 16'h0000);

        configure(1024, 2047, 65535);
        random_phase(80, 0);
        configure(0, $urandom_range(16, 1200), $urandom_range(1, 5000));
        random_phase(80, 0);
        configure(2047, 0, 1);
        random_phase(25, 0);
        configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
        random_phase(90, 1);
        configure(1, 1023, 300);
        idle_en = 0;
        random_phase(80, 0);

        drain();
        sb.close_out();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pgb_pkg.sv
rtl/core/pgb_item_if.sv
rtl/core/pgb_result_if.sv
rtl/core/pgb_front.sv
rtl/core/pgb_queue.sv
rtl/core/pgb_back.sv
rtl/core/proportional_glyph_blitter.sv
test/testbench.sv
